// File: sv/uspd_pkg.sv
// Package: shared constants, types and helpers for the URI split and percent decoder.
`default_nettype none

package uspd_pkg;

  // Buffer geometry
  localparam int BUFFER_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;

  // Item kinds on the request channel
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;

  // Element codes; one past the fragment means parsing is done
  localparam logic [2:0] ELEM_SCHEME = 3'd0;
  localparam logic [2:0] ELEM_AUTH   = 3'd1;
  localparam logic [2:0] ELEM_PATH   = 3'd2;
  localparam logic [2:0] ELEM_QUERY  = 3'd3;
  localparam logic [2:0] ELEM_FRAG   = 3'd4;
  localparam logic [2:0] STAGE_DONE  = 3'd5;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_HI,
    ST_LO,
    ST_SEARCH
  } ctl_state_t;

  // Read address select for the store
  typedef enum logic [1:0] {
    RD_POS,
    RD_POS1,
    RD_POS2,
    RD_SCAN
  } rd_sel_t;

  // Result to place in the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_EMPTY,
    EMIT_CHAR,
    EMIT_ESC,
    EMIT_MARK
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    cap_hi;
    rd_sel_t rd_sel;
    emit_t   emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;
    logic at_end;
    logic is_pct;
    logic esc_room;
    logic esc_ok;
    logic scan_busy;
  } dp_stat_t;

  // One result item
  typedef struct packed {
    logic       valid_res;
    logic [7:0] out_byte;
    logic [2:0] element;
    logic       end_marker;
    logic       final_res;
    logic       overflow;
  } res_t;

  // Hex digit decode: {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/uspd_req_if.sv
// Interface: request channel carrying load and pull items.
`default_nettype none

interface uspd_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output kind, output data_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input last_byte,
                  output ready);
endinterface

`default_nettype wire

// File: sv/uspd_rsp_if.sv
// Interface: response channel carrying decoded bytes and end markers.
`default_nettype none

interface uspd_rsp_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [7:0] out_byte;
  logic [2:0] element;
  logic       end_marker;
  logic       final_res;
  logic       overflow;

  modport source (output valid, output valid_res, output out_byte, output element,
                  output end_marker, output final_res, output overflow, input ready);
  modport sink   (input valid, input valid_res, input out_byte, input element,
                  input end_marker, input final_res, input overflow, output ready);
endinterface

`default_nettype wire

// File: sv/uspd_ctrl.sv
// Controller: handshake and sequencing of loads, pulls, escapes and terminator scans.
`default_nettype none

module uspd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_kind,
  input  wire logic               in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire uspd_pkg::dp_stat_t stat,
  output uspd_pkg::dp_cmd_t       cmd
);

  uspd_pkg::ctl_state_t state;
  uspd_pkg::ctl_state_t state_next;
  logic                 accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uspd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != uspd_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.cap_hi = 1'b0;
    cmd.rd_sel = uspd_pkg::RD_POS;
    cmd.emit   = uspd_pkg::EMIT_NONE;
    in_ready   = (state == uspd_pkg::ST_IDLE) && (!out_valid || out_ready);
    accept     = in_valid && in_ready;

    case (state)
      uspd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == uspd_pkg::KIND_LOAD) begin
            cmd.load = 1'b1;
            if (in_last) begin
              state_next = uspd_pkg::ST_SEARCH;
            end
          end else if (!stat.active) begin
            cmd.emit = uspd_pkg::EMIT_EMPTY;
          end else if (stat.at_end) begin
            cmd.emit   = uspd_pkg::EMIT_MARK;
            state_next = uspd_pkg::ST_SEARCH;
          end else begin
            state_next = uspd_pkg::ST_CHAR;
          end
        end
      end
      uspd_pkg::ST_CHAR: begin
        // plain byte, start of an escape, or a cut-off escape
        if (!stat.is_pct) begin
          cmd.emit   = uspd_pkg::EMIT_CHAR;
          state_next = uspd_pkg::ST_IDLE;
        end else if (stat.esc_room) begin
          cmd.rd_sel = uspd_pkg::RD_POS1;
          state_next = uspd_pkg::ST_HI;
        end else begin
          cmd.emit   = uspd_pkg::EMIT_MARK;
          state_next = uspd_pkg::ST_SEARCH;
        end
      end
      uspd_pkg::ST_HI: begin
        cmd.cap_hi = 1'b1;
        cmd.rd_sel = uspd_pkg::RD_POS2;
        state_next = uspd_pkg::ST_LO;
      end
      uspd_pkg::ST_LO: begin
        if (stat.esc_ok) begin
          cmd.emit   = uspd_pkg::EMIT_ESC;
          state_next = uspd_pkg::ST_IDLE;
        end else begin
          cmd.emit   = uspd_pkg::EMIT_MARK;
          state_next = uspd_pkg::ST_SEARCH;
        end
      end
      uspd_pkg::ST_SEARCH: begin
        cmd.rd_sel = uspd_pkg::RD_SCAN;
        if (!stat.scan_busy) begin
          state_next = uspd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = uspd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/uspd_datapath.sv
// Datapath: URI store, element bounds, terminator scan, escape decode and result register.
`default_nettype none

module uspd_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  input  wire uspd_pkg::dp_cmd_t  cmd,
  output uspd_pkg::dp_stat_t      stat,
  output uspd_pkg::res_t          res
);

  localparam int AW = uspd_pkg::ADDR_W;
  localparam int CW = uspd_pkg::CNT_W;

  // Store and its read port
  logic [7:0]    mem [uspd_pkg::BUFFER_DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  // Control state
  logic [CW-1:0] load_count, load_count_next;
  logic          overflow_flag, overflow_flag_next;
  logic          loaded_flag, loaded_flag_next;
  logic [CW-1:0] parse_pos, parse_pos_next;
  logic [CW-1:0] elem_end, elem_end_next;
  logic [2:0]    stage, stage_next;
  logic          stop_after, stop_after_next;
  logic          scan_busy, scan_busy_next;
  logic [CW-1:0] scan_pos, scan_pos_next;
  logic          rd_pend, rd_pend_next;
  logic [1:0]    match_cnt, match_cnt_next;
  logic [CW-1:0] rd_pos;

  // Escape high and low digits
  logic [4:0]    hi_dig;
  logic [4:0]    lo_dig;

  // Scratch
  logic [CW-1:0] cnt_eff;
  logic          start;
  logic [2:0]    start_stage;
  logic [CW-1:0] start_pos;
  logic          issue;
  logic          hit;
  logic [CW-1:0] hit_pos;
  logic [7:0]    term_ch;

  assign lo_dig = uspd_pkg::hex_val(rd_data);

  // Status toward the controller
  always_comb begin
    stat.active    = loaded_flag && (stage < uspd_pkg::STAGE_DONE);
    stat.at_end    = !(parse_pos < elem_end);
    stat.is_pct    = (rd_data == uspd_pkg::CH_PCT);
    stat.esc_room  = (({1'b0, parse_pos} + (CW+1)'(2)) < {1'b0, elem_end});
    stat.esc_ok    = hi_dig[4] && lo_dig[4] && ((hi_dig[3:0] | lo_dig[3:0]) != 4'd0);
    stat.scan_busy = scan_busy;
  end

  // Select the read address
  always_comb begin
    case (cmd.rd_sel)
      uspd_pkg::RD_POS:  rd_addr = parse_pos[AW-1:0];
      uspd_pkg::RD_POS1: rd_addr = AW'(parse_pos + CW'(1));
      uspd_pkg::RD_POS2: rd_addr = AW'(parse_pos + CW'(2));
      uspd_pkg::RD_SCAN: rd_addr = scan_pos[AW-1:0];
      default:           rd_addr = parse_pos[AW-1:0];
    endcase
  end

  // Next values of the control state
  always_comb begin
    load_count_next    = load_count;
    overflow_flag_next = overflow_flag;
    loaded_flag_next   = loaded_flag;
    parse_pos_next     = parse_pos;
    elem_end_next      = elem_end;
    stage_next         = stage;
    stop_after_next    = stop_after;
    scan_busy_next     = scan_busy;
    scan_pos_next      = scan_pos;
    rd_pend_next       = 1'b0;
    match_cnt_next     = match_cnt;
    cnt_eff            = loaded_flag ? '0 : load_count;
    wr_en              = 1'b0;
    start              = 1'b0;
    start_stage        = stage;
    start_pos          = parse_pos;
    issue              = 1'b0;
    hit                = 1'b0;
    hit_pos            = rd_pos;

    case (stage)
      uspd_pkg::ELEM_AUTH:  term_ch = uspd_pkg::CH_SLASH;
      uspd_pkg::ELEM_PATH:  term_ch = uspd_pkg::CH_QUEST;
      default:              term_ch = uspd_pkg::CH_HASH;
    endcase

    // Load one byte; a pending URI is dropped first
    if (cmd.load) begin
      load_count_next = cnt_eff;
      if (loaded_flag) begin
        overflow_flag_next = 1'b0;
        loaded_flag_next   = 1'b0;
      end
      if (data_byte != 8'd0) begin
        if (cnt_eff < CW'(uspd_pkg::BUFFER_DEPTH)) begin
          wr_en           = 1'b1;
          load_count_next = cnt_eff + CW'(1);
        end else begin
          overflow_flag_next = 1'b1;
        end
      end
      if (last_byte) begin
        loaded_flag_next = 1'b1;
        start            = 1'b1;
        start_stage      = uspd_pkg::ELEM_SCHEME;
        start_pos        = '0;
      end
    end

    // Advance past what was emitted
    case (cmd.emit)
      uspd_pkg::EMIT_CHAR: parse_pos_next = parse_pos + CW'(1);
      uspd_pkg::EMIT_ESC:  parse_pos_next = parse_pos + CW'(3);
      uspd_pkg::EMIT_MARK: begin
        if (stop_after) begin
          stage_next         = uspd_pkg::STAGE_DONE;
          loaded_flag_next   = 1'b0;
          load_count_next    = '0;
          overflow_flag_next = 1'b0;
        end else begin
          start       = 1'b1;
          start_stage = stage + 3'd1;
          start_pos   = elem_end + ((stage == uspd_pkg::ELEM_SCHEME) ? CW'(3) : CW'(1));
        end
      end
      default: ;
    endcase

    // Walk the store one byte a cycle looking for the terminator
    if (scan_busy) begin
      issue = scan_pos < load_count;
      if (issue) begin
        scan_pos_next = scan_pos + CW'(1);
      end
      rd_pend_next = issue;
      if (rd_pend) begin
        if (stage == uspd_pkg::ELEM_SCHEME) begin
          if (match_cnt == 2'd2 && rd_data == uspd_pkg::CH_SLASH) begin
            hit     = 1'b1;
            hit_pos = rd_pos - CW'(2);
          end else if (rd_data == uspd_pkg::CH_COLON) begin
            match_cnt_next = 2'd1;
          end else if (match_cnt == 2'd1 && rd_data == uspd_pkg::CH_SLASH) begin
            match_cnt_next = 2'd2;
          end else begin
            match_cnt_next = 2'd0;
          end
        end else begin
          hit = (rd_data == term_ch);
        end
      end
      if (hit) begin
        elem_end_next   = hit_pos;
        stop_after_next = ((rd_pos + CW'(1)) == load_count);
        scan_busy_next  = 1'b0;
        rd_pend_next    = 1'b0;
      end else if (!rd_pend && !issue) begin
        scan_busy_next = 1'b0;
      end
    end

    // Enter a new element: default bounds to the end of the URI
    if (start) begin
      stage_next      = start_stage;
      parse_pos_next  = start_pos;
      elem_end_next   = load_count_next;
      stop_after_next = 1'b1;
      scan_pos_next   = start_pos;
      match_cnt_next  = 2'd0;
      rd_pend_next    = 1'b0;
      scan_busy_next  = (start_stage != uspd_pkg::ELEM_FRAG);
    end
  end

  assign wr_addr = cnt_eff[AW-1:0];

  // Store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= data_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= '0;
      overflow_flag <= 1'b0;
      loaded_flag   <= 1'b0;
      parse_pos     <= '0;
      elem_end      <= '0;
      stage         <= uspd_pkg::ELEM_SCHEME;
      stop_after    <= 1'b0;
      scan_busy     <= 1'b0;
      scan_pos      <= '0;
      rd_pend       <= 1'b0;
      match_cnt     <= 2'd0;
    end else begin
      load_count    <= load_count_next;
      overflow_flag <= overflow_flag_next;
      loaded_flag   <= loaded_flag_next;
      parse_pos     <= parse_pos_next;
      elem_end      <= elem_end_next;
      stage         <= stage_next;
      stop_after    <= stop_after_next;
      scan_busy     <= scan_busy_next;
      scan_pos      <= scan_pos_next;
      rd_pend       <= rd_pend_next;
      match_cnt     <= match_cnt_next;
    end
  end

  // Payload registers: scan tag, escape digit, result
  always_ff @(posedge clk) begin
    rd_pos <= scan_pos;
    if (cmd.cap_hi) begin
      hi_dig <= lo_dig;
    end
    if (cmd.emit != uspd_pkg::EMIT_NONE) begin
      res.valid_res  <= (cmd.emit != uspd_pkg::EMIT_EMPTY);
      res.end_marker <= (cmd.emit == uspd_pkg::EMIT_MARK);
      res.final_res  <= (cmd.emit == uspd_pkg::EMIT_MARK) && stop_after;
      res.element    <= (cmd.emit == uspd_pkg::EMIT_EMPTY) ? 3'd0 : stage;
      res.overflow   <= (cmd.emit != uspd_pkg::EMIT_EMPTY) && overflow_flag;
      case (cmd.emit)
        uspd_pkg::EMIT_CHAR: res.out_byte <= rd_data;
        uspd_pkg::EMIT_ESC:  res.out_byte <= {hi_dig[3:0], lo_dig[3:0]};
        default:             res.out_byte <= 8'd0;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/uri_split_percent_decode.sv
// Top level: URI split into elements with percent decoding, loaded and pulled over two channels.
//
//   channel  dir  payload                                                     role
//   req      in   kind, data_byte, last_byte                                   load byte / pull
//   rsp      out  valid_res, out_byte, element, end_marker, final_res, overflow one per pull
//
// A load writes the store directly. A pull of a plain byte passes ST_CHAR; one of an escape
// also passes ST_HI and ST_LO, set by the single registered read port of the 1024-byte store.
// After the last byte and after each end marker that does not close the URI, a terminator
// scan walks the stored bytes at one per cycle with req.ready low; none runs for the fragment.
// rst is synchronous and clears control state; the store keeps its contents.
// A result held on rsp keeps req.ready low until it is taken.
`default_nettype none

module uri_split_percent_decode (
  input  wire logic  clk,
  input  wire logic  rst,
  uspd_req_if.sink   req,
  uspd_rsp_if.source rsp
);

  uspd_pkg::dp_cmd_t  cmd;
  uspd_pkg::dp_stat_t stat;
  uspd_pkg::res_t     res;
  logic               in_ready;
  logic               out_valid;

  uspd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_kind   (req.kind),
    .in_last   (req.last_byte),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  uspd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (req.data_byte),
    .last_byte (req.last_byte),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res)
  );

  // Drive the channels
  assign req.ready      = in_ready;
  assign rsp.valid      = out_valid;
  assign rsp.valid_res  = res.valid_res;
  assign rsp.out_byte   = res.out_byte;
  assign rsp.element    = res.element;
  assign rsp.end_marker = res.end_marker;
  assign rsp.final_res  = res.final_res;
  assign rsp.overflow   = res.overflow;

endmodule

`default_nettype wire

// File: sv/uspd_checker.sv
// Checker: port-level properties of the URI decoder, bound to the top level.
`default_nettype none

module uspd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       rsp_valid_res,
  input wire logic [7:0] rsp_out_byte,
  input wire logic [2:0] rsp_element,
  input wire logic       rsp_end_marker,
  input wire logic       rsp_final_res,
  input wire logic       rsp_overflow
);

  // An empty pull carries nothing else
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_valid_res) |->
      (rsp_out_byte == 8'd0 && rsp_element == 3'd0 && !rsp_end_marker &&
       !rsp_final_res && !rsp_overflow))
    else $error("empty pull result carries nonzero fields");

  // Only an end marker closes the URI, and a marker carries no byte
  a_final_is_marker: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_final_res) |-> (rsp_end_marker && rsp_out_byte == 8'd0))
    else $error("final item is not a bare end marker");

  // A decoded byte is never zero and belongs to one of the five elements
  a_byte_nonzero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_valid_res && !rsp_end_marker) |->
      (rsp_out_byte != 8'd0 && rsp_element <= 3'd4))
    else $error("decoded byte is zero or element out of range");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_end_marker) &&
       $stable(rsp_final_res)))
    else $error("stalled result changed");

endmodule

bind uri_split_percent_decode uspd_checker u_uspd_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_valid_res  (rsp.valid_res),
  .rsp_out_byte   (rsp.out_byte),
  .rsp_element    (rsp.element),
  .rsp_end_marker (rsp.end_marker),
  .rsp_final_res  (rsp.final_res),
  .rsp_overflow   (rsp.overflow)
);

`default_nettype wire

// File: tb/uri_decode_checker.sv
// Checker: watches both channels, models the URI split and decode, and compares every response.
`timescale 1ns / 100ps

module uri_decode_checker (
  input  logic clk,
  input  logic rst,
  uspd_req_if  req,
  uspd_rsp_if  rsp,
  output int   mismatch_cnt,
  output int   open_cnt
);
  import uspd_pkg::*;

  // Model state: stored URI, load length and the position of the element walk
  logic [7:0]       uri_mem [BUFFER_DEPTH];
  logic [CNT_W-1:0] fill_len;
  logic             uri_loaded;
  logic [CNT_W-1:0] scan_pos;
  logic [CNT_W-1:0] elem_end;
  logic [2:0]       cur_elem;
  logic             stop_here;
  logic             trunc_flag;

  // Decoded items still owed by the block, oldest first
  res_t decoded_q [$];

  function automatic int nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - 8'h30);
    if (c >= "a" && c <= "f") return int'(c - 8'h57);
    if (c >= "A" && c <= "F") return int'(c - 8'h37);
    return -1;
  endfunction

  // The scheme ends at "://", every later element at one character
  function automatic int term_len(input logic [2:0] e);
    return (e == ELEM_SCHEME) ? 3 : 1;
  endfunction

  function automatic logic term_hit(input logic [2:0] e, input int q);
    case (e)
      ELEM_SCHEME: return uri_mem[ADDR_W'(q)] == CH_COLON &&
                          uri_mem[ADDR_W'(q + 1)] == CH_SLASH &&
                          uri_mem[ADDR_W'(q + 2)] == CH_SLASH;
      ELEM_AUTH:   return uri_mem[ADDR_W'(q)] == CH_SLASH;
      ELEM_PATH:   return uri_mem[ADDR_W'(q)] == CH_QUEST;
      default:     return uri_mem[ADDR_W'(q)] == CH_HASH;
    endcase
  endfunction

  // Find the bounds of element e, which starts at scan_pos
  function automatic void open_element(input logic [2:0] e);
    int n, span, q;
    n         = int'(fill_len);
    span      = term_len(e);
    cur_elem  = e;
    elem_end  = fill_len;
    stop_here = 1'b1;
    if (e >= ELEM_FRAG) return;
    for (q = int'(scan_pos); q + span <= n; q++) begin
      if (term_hit(e, q)) begin
        elem_end  = CNT_W'(q);
        stop_here = (q + span >= n);
        return;
      end
    end
  endfunction

  // Store one byte; a load after a finished load starts a new URI
  function automatic void load_byte(input logic [7:0] d, input logic last);
    if (uri_loaded) begin
      fill_len   = '0;
      trunc_flag = 1'b0;
      uri_loaded = 1'b0;
    end
    if (d != 8'h00) begin
      if (fill_len < BUFFER_DEPTH) begin
        uri_mem[fill_len[ADDR_W-1:0]] = d;
        fill_len                      = fill_len + 1'b1;
      end else begin
        trunc_flag = 1'b1;
      end
    end
    if (last) begin
      uri_loaded = 1'b1;
      scan_pos   = '0;
      open_element(ELEM_SCHEME);
    end
  endfunction

  // Produce the item that one pull returns
  function automatic res_t decode_step();
    res_t r;
    int   hi, lo;
    logic mark;
    r    = '0;
    mark = 1'b0;
    if (!uri_loaded || cur_elem >= STAGE_DONE) return r;
    r.valid_res = 1'b1;
    r.element   = cur_elem;
    if (scan_pos < elem_end) begin
      if (uri_mem[scan_pos[ADDR_W-1:0]] == CH_PCT) begin
        if (scan_pos + 2 < elem_end) begin
          hi = nibble(uri_mem[ADDR_W'(scan_pos + 1)]);
          lo = nibble(uri_mem[ADDR_W'(scan_pos + 2)]);
          if (hi >= 0 && lo >= 0 && (hi | lo) != 0) begin
            r.out_byte = 8'(hi * 16 + lo);
            scan_pos   = scan_pos + 3'd3;
          end else begin
            mark = 1'b1;
          end
        end else begin
          mark = 1'b1;
        end
      end else begin
        r.out_byte = uri_mem[scan_pos[ADDR_W-1:0]];
        scan_pos   = scan_pos + 1'b1;
      end
    end else begin
      mark = 1'b1;
    end
    // Close the element; either stop or move past its terminator
    if (mark) begin
      r.end_marker = 1'b1;
      r.final_res  = stop_here;
      if (stop_here) begin
        cur_elem   = STAGE_DONE;
        uri_loaded = 1'b0;
        fill_len   = '0;
      end else begin
        scan_pos = CNT_W'(int'(elem_end) + term_len(cur_elem));
        open_element(cur_elem + 3'd1);
      end
    end
    r.overflow = trunc_flag;
    if (r.final_res) trunc_flag = 1'b0;
    return r;
  endfunction

  function automatic int field_bad(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    res_t seen, due;
    int   bad;
    if (rst) begin
      fill_len   = '0;
      uri_loaded = 1'b0;
      scan_pos   = '0;
      elem_end   = '0;
      cur_elem   = ELEM_SCHEME;
      stop_here  = 1'b0;
      trunc_flag = 1'b0;
      decoded_q.delete();
      mismatch_cnt <= 0;
      open_cnt     <= 0;
    end else begin
      bad = 0;
      // Compare each accepted response item with the oldest owed item
      if (rsp.valid && rsp.ready) begin
        seen = {rsp.valid_res, rsp.out_byte, rsp.element, rsp.end_marker, rsp.final_res,
                rsp.overflow};
        if (decoded_q.size() == 0) begin
          $display("%0t: response item expected none got %h", $time, seen);
          bad = 1;
        end else begin
          due = decoded_q.pop_front();
          bad = field_bad("valid_res", 8'(due.valid_res), 8'(seen.valid_res))
              + field_bad("out_byte", due.out_byte, seen.out_byte)
              + field_bad("element", 8'(due.element), 8'(seen.element))
              + field_bad("end_marker", 8'(due.end_marker), 8'(seen.end_marker))
              + field_bad("final_res", 8'(due.final_res), 8'(seen.final_res))
              + field_bad("overflow", 8'(due.overflow), 8'(seen.overflow));
        end
      end
      // Advance the model on each accepted request item
      if (req.valid && req.ready) begin
        if (req.kind == KIND_LOAD) begin
          load_byte(req.data_byte, req.last_byte);
        end else begin
          decoded_q.push_back(decode_step());
        end
      end
      if (bad != 0) mismatch_cnt <= mismatch_cnt + 1;
      open_cnt <= decoded_q.size();
    end
  end

endmodule

// File: tb/uri_split_percent_decode_tb.sv
// Testbench top: clock, reset, load and pull traffic, response stalls and the verdict.
`timescale 1ns / 100ps

module uri_split_percent_decode_tb;
  import uspd_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS   = 60;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst;
  int   mismatch_cnt;
  int   open_cnt;
  int   cycle_cnt = 0;
  int   sent_cnt  = 0;
  logic quiet     = 1'b0;   // no idling on either side
  logic hold_rsp  = 1'b0;   // one long stall of the response side

  logic [7:0] uri_text [$];
  string      plain_set = "abcdefghijklmnopqrstuvwxyz0123456789-._~";
  string      mark_set  = ":/?#%";

  uspd_req_if req_ch ();
  uspd_rsp_if rsp_ch ();

  uri_split_percent_decode u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  uri_decode_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .mismatch_cnt (mismatch_cnt),
    .open_cnt     (open_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL uri_split_percent_decode");
      $finish;
    end
  end

  // Response side: random stall bursts, plus one long hold on request
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offer one item, maybe after an idle burst, and hold it until accepted
  task automatic send_item(input logic kind, input logic [7:0] data, input logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.data_byte <= data;
    req_ch.last_byte <= last;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_cnt++;
  endtask

  // Stop offering until every owed response item has arrived
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
  endtask

  task automatic pull_n(input int count);
    repeat (count) send_item(KIND_PULL, 8'($urandom), 1'($urandom));
  endtask

  // Load uri_text; noisy loads mix in dropped zero bytes and early pulls
  task automatic load_uri(input bit noisy);
    int i;
    bit zero_end;
    zero_end = (noisy && $urandom_range(0, 3) == 0) || uri_text.size() == 0;
    for (i = 0; i < uri_text.size(); i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_item(KIND_LOAD, 8'h00, 1'b0);
      if (noisy && $urandom_range(0, 15) == 0) pull_n(1);
      send_item(KIND_LOAD, uri_text[i], !zero_end && i == uri_text.size() - 1);
    end
    if (zero_end) send_item(KIND_LOAD, 8'h00, 1'b1);
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) uri_text.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  // Element content: plain characters, escapes, and now and then a broken one
  task automatic add_text(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 15))
        0, 1: begin
          uri_text.push_back(CH_PCT);
          uri_text.push_back(hex_char(int'($urandom_range(0, 15))));
          uri_text.push_back(hex_char(int'($urandom_range(0, 15))));
        end
        2: begin
          // short escape: cut off at the element end, bad before a letter
          uri_text.push_back(CH_PCT);
          if ($urandom_range(0, 1) != 0) uri_text.push_back(hex_char(int'($urandom_range(0, 15))));
        end
        3: put_text("%00");
        4: uri_text.push_back(8'($urandom_range(1, 255)));
        default: uri_text.push_back(plain_set[$urandom_range(0, plain_set.len() - 1)]);
      endcase
    end
  endtask

  // Well-formed URI with optional parts and random content
  task automatic make_uri(input int span);
    uri_text.delete();
    if ($urandom_range(0, 7) != 0) begin
      add_text($urandom_range(0, span));
      put_text("://");
    end
    add_text($urandom_range(0, span));
    if ($urandom_range(0, 3) != 0) begin
      put_text("/");
      add_text($urandom_range(0, span));
    end
    if ($urandom_range(0, 1) != 0) begin
      put_text("?");
      add_text($urandom_range(0, span));
    end
    if ($urandom_range(0, 1) != 0) begin
      put_text("#");
      add_text($urandom_range(0, span));
    end
  endtask

  // Random bytes, rich in delimiters
  task automatic make_noise(input int len);
    uri_text.delete();
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) begin
        uri_text.push_back(mark_set[$urandom_range(0, mark_set.len() - 1)]);
      end else begin
        uri_text.push_back(8'($urandom_range(1, 255)));
      end
    end
  endtask

  initial begin
    int pulls;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.kind      <= KIND_LOAD;
    req_ch.data_byte <= 8'h00;
    req_ch.last_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: pull with nothing loaded, every element with escapes of each kind
    send_item(KIND_PULL, 8'hFF, 1'b1);
    uri_text.delete();
    uri_text.push_back(8'hFF);
    put_text("://%4a");
    uri_text.push_back(8'h01);
    put_text("/%00?%G1#%2");
    load_uri(1'b0);
    pull_n(9);
    // Empty URI: a lone zero byte that ends the load
    uri_text.delete();
    load_uri(1'b0);
    pull_n(2);
    drain_results();

    // Overflowing URI: two bytes, then a bad escape ends it; pulled under a long stall
    uri_text.delete();
    put_text("ab%G");
    repeat (BUFFER_DEPTH + 4) uri_text.push_back("x");
    load_uri(1'b0);
    hold_rsp = 1'b1;
    pull_n(40);
    drain_results();

    // Random URIs, mostly well formed; some left half pulled and replaced
    sent_cnt = 0;
    while (sent_cnt < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        make_uri(6);
      end else begin
        make_noise($urandom_range(0, 20));
      end
      if (sent_cnt > RANDOM_ITEMS - CALM_ITEMS) quiet = 1'b1;
      load_uri($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        pulls = $urandom_range(0, uri_text.size());
      end else begin
        pulls = uri_text.size() + 5;
      end
      pull_n(pulls);
    end

    // Wait out the owed items and any late traffic
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS uri_split_percent_decode");
    end else begin
      $display("FAIL uri_split_percent_decode");
    end
    $finish;
  end

endmodule
